// File: hw/rtl/url_percent_decoder_assert.svh
// ----------------------------------------------------------------------------
// URL percent decoder assertion macros
// Shorthands for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_ASSERT_SVH
`define URL_PERCENT_DECODER_ASSERT_SVH

// Check that is switched off while the reset is asserted.
`define UPD_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check that holds at every clock edge, reset included.
`define UPD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character codes, the safe-character table and hex decoding.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

    // Character codes with a special meaning.
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes (byte address is 8 times the index).
    localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd0;
    localparam logic [2:0] REG_ALLOW_MASK_LO  = 3'd1;
    localparam logic [2:0] REG_ALLOW_MASK_MID = 3'd2;
    localparam logic [2:0] REG_ALLOW_MASK_HI  = 3'd3;
    localparam logic [2:0] REG_ALLOW_MASK_TOP = 3'd4;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int OUT_CNT_W  = 16;

    // One bit per byte value: space ! $ ' ( ) * , - . 0-9 A-Z _ a-z.
    localparam logic [255:0] SAFE_MASK = {
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h07FF_FFFE_87FF_FFFE,
        64'h03FF_7793_0000_0000
    };

    // Configuration seen by the decode logic.
    typedef struct packed {
        logic [15:0]  output_limit;
        logic [255:0] allow_mask;
    } cfg_t;

    // One result of a decode step.
    typedef struct packed {
        logic                 valid;
        logic                 data_valid;
        logic [7:0]           decoded_byte;
        logic                 done_res;
        logic                 success;
        logic [OUT_CNT_W-1:0] consumed_count;
        logic [OUT_CNT_W-1:0] produced_count;
    } result_t;

    // Hex digit value in the low four bits; the top bit flags a bad digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/upd_cfg_regs.sv
// ----------------------------------------------------------------------------
// URL percent decoder configuration registers
// APB-style register file for the output limit and the 256-bit allow mask.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_cfg_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [upd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [upd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [upd_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output upd_pkg::cfg_t                      cfg
);

    logic [15:0] limit_reg;
    logic [63:0] mask_lo_reg;
    logic [63:0] mask_mid_reg;
    logic [63:0] mask_hi_reg;
    logic [63:0] mask_top_reg;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[5:3];
    assign wr_en     = psel & penable & pwrite & pready;

    // Register writes during the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg    <= 16'hFFFF;
            mask_lo_reg  <= '0;
            mask_mid_reg <= '0;
            mask_hi_reg  <= '0;
            mask_top_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                upd_pkg::REG_OUTPUT_LIMIT:   limit_reg    <= pwdata[15:0];
                upd_pkg::REG_ALLOW_MASK_LO:  mask_lo_reg  <= pwdata;
                upd_pkg::REG_ALLOW_MASK_MID: mask_mid_reg <= pwdata;
                upd_pkg::REG_ALLOW_MASK_HI:  mask_hi_reg  <= pwdata;
                upd_pkg::REG_ALLOW_MASK_TOP: mask_top_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_index)
            upd_pkg::REG_OUTPUT_LIMIT:   prdata = {48'b0, limit_reg};
            upd_pkg::REG_ALLOW_MASK_LO:  prdata = mask_lo_reg;
            upd_pkg::REG_ALLOW_MASK_MID: prdata = mask_mid_reg;
            upd_pkg::REG_ALLOW_MASK_HI:  prdata = mask_hi_reg;
            upd_pkg::REG_ALLOW_MASK_TOP: prdata = mask_top_reg;
            default:                     prdata = '0;
        endcase
    end

    assign cfg.output_limit = limit_reg;
    assign cfg.allow_mask   = {mask_top_reg, mask_hi_reg, mask_mid_reg, mask_lo_reg};

endmodule

`default_nettype wire

// File: hw/rtl/upd_step.sv
// ----------------------------------------------------------------------------
// URL percent decoder step logic
// Decodes one source byte against the buffer state and updates that state.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_step #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire upd_pkg::cfg_t cfg,
    input  wire logic [7:0]    src_byte,
    input  wire logic          src_last,
    input  wire logic          advance,
    output upd_pkg::result_t   res
);

    localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam int EXT_W = COUNT_WIDTH + 16;

    // Escape phase codes.
    localparam logic [1:0] ESC_IDLE = 2'd0;
    localparam logic [1:0] ESC_HI   = 2'd1;
    localparam logic [1:0] ESC_LO   = 2'd2;

    logic [1:0]             esc_reg,  esc_next;
    logic [3:0]             nib_reg,  nib_next;
    logic [COUNT_WIDTH-1:0] cons_reg, cons_next;
    logic [COUNT_WIDTH-1:0] prod_reg, prod_next;
    logic                   halt_reg, halt_next;

    logic [COUNT_WIDTH:0]   prod_sum;
    logic [COUNT_WIDTH:0]   cons_sum;
    logic [COUNT_WIDTH-1:0] prod_inc;
    logic [COUNT_WIDTH-1:0] cons_inc;
    logic [1:0]             used;
    logic [4:0]             hexv;
    logic                   allowed;
    logic                   limit_met;
    logic                   limit_hit;
    logic                   produce;
    logic                   done;
    logic                   ok;
    logic [7:0]             byte_out;
    logic [EXT_W-1:0]       cons_ext;
    logic [EXT_W-1:0]       prod_ext;

    assign hexv      = upd_pkg::hex_value(src_byte);
    assign allowed   = upd_pkg::SAFE_MASK[src_byte] | cfg.allow_mask[src_byte];
    assign limit_met = CMP_W'(prod_reg) >= CMP_W'(cfg.output_limit);

    // Saturating count updates.
    assign prod_sum = {1'b0, prod_reg} + (COUNT_WIDTH+1)'(1);
    assign cons_sum = {1'b0, cons_reg} + (COUNT_WIDTH+1)'(used);
    assign prod_inc = prod_sum[COUNT_WIDTH] ? '1 : prod_sum[COUNT_WIDTH-1:0];
    assign cons_inc = cons_sum[COUNT_WIDTH] ? '1 : cons_sum[COUNT_WIDTH-1:0];
    assign limit_hit = CMP_W'(prod_inc) >= CMP_W'(cfg.output_limit);

    // Decode of one source byte.
    always_comb begin
        esc_next  = esc_reg;
        nib_next  = nib_reg;
        cons_next = cons_reg;
        prod_next = prod_reg;
        halt_next = halt_reg;
        produce   = 1'b0;
        done      = 1'b0;
        ok        = 1'b0;
        byte_out  = 8'h00;
        used      = 2'd0;

        if (!halt_reg) begin
            if (esc_reg == ESC_IDLE) begin
                if (limit_met) begin
                    done = 1'b1;
                    ok   = 1'b1;
                end else if (src_byte == upd_pkg::CH_PCT) begin
                    if (src_last) begin
                        done = 1'b1;
                        ok   = 1'b1;
                    end else begin
                        esc_next = ESC_HI;
                    end
                end else if (src_byte == upd_pkg::CH_PLUS) begin
                    produce  = 1'b1;
                    byte_out = upd_pkg::CH_SPACE;
                    used     = 2'd1;
                end else if (allowed) begin
                    produce  = 1'b1;
                    byte_out = src_byte;
                    used     = 2'd1;
                end else begin
                    done = 1'b1;
                    ok   = (prod_reg != '0);
                end
            end else begin
                if (hexv[4]) begin
                    done = 1'b1;
                    ok   = (prod_reg != '0);
                end else if (esc_reg == ESC_HI) begin
                    if (src_last) begin
                        done = 1'b1;
                        ok   = 1'b1;
                    end else begin
                        nib_next = hexv[3:0];
                        esc_next = ESC_LO;
                    end
                end else begin
                    produce  = 1'b1;
                    byte_out = {nib_reg, hexv[3:0]};
                    used     = 2'd3;
                end
            end

            // A produced byte advances the totals and may end the buffer.
            if (produce) begin
                prod_next = prod_inc;
                cons_next = cons_inc;
                esc_next  = ESC_IDLE;
                nib_next  = 4'h0;
                if (limit_hit || src_last) begin
                    done = 1'b1;
                    ok   = 1'b1;
                end
            end
            if (!produce && !done && src_last) begin
                done = 1'b1;
                ok   = 1'b1;
            end
            if (done && !src_last) begin
                halt_next = 1'b1;
            end
        end

        // The last byte of a buffer rearms the block once it has finished.
        if (src_last && (halt_reg || done)) begin
            esc_next  = ESC_IDLE;
            nib_next  = 4'h0;
            cons_next = '0;
            prod_next = '0;
            halt_next = 1'b0;
        end
    end

    // Buffer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg  <= ESC_IDLE;
            nib_reg  <= 4'h0;
            cons_reg <= '0;
            prod_reg <= '0;
            halt_reg <= 1'b0;
        end else if (advance) begin
            esc_reg  <= esc_next;
            nib_reg  <= nib_next;
            cons_reg <= cons_next;
            prod_reg <= prod_next;
            halt_reg <= halt_next;
        end
    end

    // Result fields; the counts report the totals after this byte.
    assign cons_ext = EXT_W'(produce ? cons_inc : cons_reg);
    assign prod_ext = EXT_W'(produce ? prod_inc : prod_reg);

    assign res.valid          = produce | done;
    assign res.data_valid     = produce;
    assign res.decoded_byte   = byte_out;
    assign res.done_res       = done;
    assign res.success        = done & ok;
    assign res.consumed_count = done ? cons_ext[15:0] : 16'h0000;
    assign res.produced_count = done ? prod_ext[15:0] : 16'h0000;

endmodule

`default_nettype wire

// File: hw/rtl/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// URL percent decoder
// Streaming decoder of percent-escaped URL text, one source byte per clock unless s_tready drops.
// ----------------------------------------------------------------------------
// Usage:
//   Source bytes enter on the s_ stream, with s_tlast on a buffer's final byte.
//   Each byte that decodes to an output byte or finishes the buffer gives one
//   request on the m_ stream: m_tuser says a decoded byte is present, m_tlast
//   marks the buffer's done result, which carries success and both counts.
//   A "%hh" escape gives its byte on the second hex digit.
//   Throughput: one byte per clock unless s_tready drops, set by the single
//   decode step between the input register and the result register.
//   An accepted byte waits in the input register; its result is then captured
//   in the result register, which drives m_tvalid.
//   When the receiver stalls, the result register holds and the input register
//   still takes a byte; bytes without a result keep flowing, and s_tready
//   drops only when a byte with a result finds the result register full.
//   Reset clears the valid flags of both registers and the buffer state and
//   loads the register reset values (output limit 65535, empty allow mask).
//   The user writes the APB port only while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "url_percent_decoder_assert.svh"

module url_percent_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Source stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] src_byte
    input  wire logic        s_tlast,   // src_last
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [7:0] decoded_byte, [8] success,
                                        // [24:9] consumed_count,
                                        // [40:25] produced_count, [47:41] zero
    output logic             m_tuser,   // data_valid
    output logic             m_tlast,   // done_res
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    upd_pkg::cfg_t    cfg;
    upd_pkg::result_t res;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_dv_reg;
    logic       out_done_reg;
    logic       out_ok_reg;
    logic [15:0] out_cons_reg;
    logic [15:0] out_prod_reg;
    logic       out_free;
    logic       advance;

    // Configuration registers.
    upd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decode step on the byte in the input register.
    upd_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .src_byte (in_byte_reg),
        .src_last (in_last_reg),
        .advance  (advance),
        .res      (res)
    );

    // Flow control: a byte moves on unless its result meets a full register.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!res.valid || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_byte_reg <= res.decoded_byte;
            out_dv_reg   <= res.data_valid;
            out_done_reg <= res.done_res;
            out_ok_reg   <= res.success;
            out_cons_reg <= res.consumed_count;
            out_prod_reg <= res.produced_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_dv_reg;
    assign m_tlast  = out_done_reg;
    assign m_tdata  = {7'b0, out_prod_reg, out_cons_reg, out_ok_reg, out_byte_reg};

    // Every result carries a byte or finishes the buffer.
    `UPD_ASSERT_RST(a_result_nonempty, aclk, aresetn, m_tvalid |-> (m_tuser || m_tlast), "result with neither byte nor done")
    // Status fields are zero on a result that does not finish the buffer.
    `UPD_ASSERT_RST(a_status_on_done, aclk, aresetn, (m_tvalid && !m_tlast) |-> (m_tdata[40:8] == 33'd0), "status set without done")
    // A result without a byte carries a zero byte.
    `UPD_ASSERT_RST(a_byte_zero, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'h00), "byte set without data_valid")
    // Reset leaves no result pending and the input open.
    `UPD_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> (!m_tvalid && s_tready), "reset left stale state")

endmodule

`default_nettype wire
